// ===== hdl/glmf_pkg.sv =====
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared constants and types of the grid local maximum finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glmf_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_HEIGHT_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths of the register port and of the result items.
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;
	localparam int COORD_W     = 10;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	// Number of candidate results one sample can decide.
	localparam int NUM_CHECKS = 4;

	// Where a sample sits in the grid; travels with the sample down the pipe.
	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic row_last;
		logic col_zero;
		logic col_ge1;
		logic col_last;
	} pos_flags_t;

endpackage

// ===== hdl/glmf_if.sv =====
// ----------------------------------------------------------------------------
// glmf channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface glmf_sample_if #(
	parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

interface glmf_peak_if;
	import glmf_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] peak_row;
	logic [COORD_W-1:0] peak_col;
	logic               last_of_run;

	modport source (output valid, output peak_row, output peak_col, output last_of_run,
		input ready);
	modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
		output ready);
endinterface

interface glmf_cfg_if;
	import glmf_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/glmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// glmf_ctrl
// Grid size registers and the raster position of the next sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glmf_ctrl #(
	parameter int MAX_WIDTH  = glmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = glmf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	glmf_cfg_if.sink                        cfg,
	input  logic                            acc,
	output logic [$clog2(MAX_WIDTH)-1:0]    col,
	output logic [$clog2(MAX_HEIGHT)-1:0]   row,
	output glmf_pkg::pos_flags_t            flags
);
	import glmf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WC_W  = $clog2(MAX_WIDTH + 1);
	localparam int HC_W  = $clog2(MAX_HEIGHT + 1);
	localparam int WX_W  = (WC_W > CFG_DATA_W) ? WC_W : CFG_DATA_W;
	localparam int HX_W  = (HC_W > CFG_DATA_W) ? HC_W : CFG_DATA_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] wlast_q;
	logic [ROW_W-1:0] hlast_q;
	logic [COL_W-1:0] wlast_new;
	logic [ROW_W-1:0] hlast_new;
	logic [WX_W-1:0]  wext;
	logic [HX_W-1:0]  hext;
	logic             cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid;

	// A size of zero acts as one, a size above the maximum as the maximum.
	always_comb begin
		wext = WX_W'(cfg.data);
		hext = HX_W'(cfg.data);
		if (wext == '0) begin
			wlast_new = '0;
		end else if (wext > WX_W'(MAX_WIDTH)) begin
			wlast_new = COL_W'(MAX_WIDTH - 1);
		end else begin
			wlast_new = COL_W'(wext - WX_W'(1));
		end
		if (hext == '0) begin
			hlast_new = '0;
		end else if (hext > HX_W'(MAX_HEIGHT)) begin
			hlast_new = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hlast_new = ROW_W'(hext - HX_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			wlast_q <= '0;
			hlast_q <= '0;
		end else if (cfg_wr && (cfg.index == REG_GRID_WIDTH || cfg.index == REG_GRID_HEIGHT)) begin
			if (cfg.index == REG_GRID_WIDTH) begin
				wlast_q <= wlast_new;
			end else begin
				hlast_q <= hlast_new;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign col            = col_q;
	assign row            = row_q;
	assign flags.row_ge1  = (row_q != '0);
	assign flags.row_ge2  = (row_q > ROW_W'(1));
	assign flags.row_last = (row_q == hlast_q);
	assign flags.col_zero = (col_q == '0);
	assign flags.col_ge1  = (col_q != '0);
	assign flags.col_last = (col_q == wlast_q);

endmodule

// ===== hdl/glmf_line_store.sv =====
// ----------------------------------------------------------------------------
// glmf_line_store
// Two line memories holding the previous two rows, with write forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glmf_line_store #(
	parameter int MAX_WIDTH   = glmf_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
	input  logic                            wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
	input  logic signed [SAMPLE_BITS-1:0]   wr_upper,
	input  logic signed [SAMPLE_BITS-1:0]   wr_lower,
	output logic signed [SAMPLE_BITS-1:0]   rd_upper,
	output logic signed [SAMPLE_BITS-1:0]   rd_lower
);
	import glmf_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem_upper [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] mem_lower [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] rdata_upper_q;
	logic signed [SAMPLE_BITS-1:0] rdata_lower_q;
	logic signed [SAMPLE_BITS-1:0] fwd_upper_q;
	logic signed [SAMPLE_BITS-1:0] fwd_lower_q;
	logic                          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_upper[wr_addr] <= wr_upper;
			mem_lower[wr_addr] <= wr_lower;
		end
		if (rd_en) begin
			rdata_upper_q <= mem_upper[rd_addr];
			rdata_lower_q <= mem_lower[rd_addr];
			fwd_upper_q   <= wr_upper;
			fwd_lower_q   <= wr_lower;
		end
	end

	// With a one-column grid the read of a column meets the write of the same
	// column in the same cycle; the data being written then replaces the stale read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_upper = fwd_q ? fwd_upper_q : rdata_upper_q;
	assign rd_lower = fwd_q ? fwd_lower_q : rdata_lower_q;

endmodule

// ===== hdl/glmf_window.sv =====
// ----------------------------------------------------------------------------
// glmf_window
// 3x3 window update and the four hilltop checks of one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glmf_window #(
	parameter int MAX_WIDTH   = glmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = glmf_pkg::MAX_HEIGHT_DEF,
	parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  acc,
	input  logic signed [SAMPLE_BITS-1:0]         sample_value,
	input  logic [$clog2(MAX_WIDTH)-1:0]          col,
	input  logic [$clog2(MAX_HEIGHT)-1:0]         row,
	input  glmf_pkg::pos_flags_t                  flags,
	input  logic signed [SAMPLE_BITS-1:0]         rd_upper,
	input  logic signed [SAMPLE_BITS-1:0]         rd_lower,
	output logic                                  wr_en,
	output logic [$clog2(MAX_WIDTH)-1:0]          wr_addr,
	output logic signed [SAMPLE_BITS-1:0]         wr_upper,
	output logic signed [SAMPLE_BITS-1:0]         wr_lower,
	output logic [glmf_pkg::NUM_CHECKS-1:0]       pend,
	output logic [$clog2(MAX_HEIGHT)-1:0]         row_out,
	output logic [$clog2(MAX_WIDTH)-1:0]          col_out
);
	import glmf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic                          v_s1;
	logic                          v_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [COL_W-1:0]              col_s1;
	logic [COL_W-1:0]              col_s2;
	logic [ROW_W-1:0]              row_s1;
	logic [ROW_W-1:0]              row_s2;
	pos_flags_t                    flags_s1;
	pos_flags_t                    flags_s2;
	logic signed [SAMPLE_BITS-1:0] win_q    [3][3];
	logic signed [SAMPLE_BITS-1:0] win_next [3][3];
	logic signed [SAMPLE_BITS-1:0] up_val;
	logic signed [SAMPLE_BITS-1:0] lo_val;
	logic [NUM_CHECKS-1:0]         hit;
	logic [NUM_CHECKS-1:0]         cond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= sample_value;
			col_s1    <= col;
			row_s1    <= row;
			flags_s1  <= flags;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			flags_s2  <= flags_s1;
			if (v_s1) begin
				win_q <= win_next;
			end
		end
	end

	// Rows above the grid read as the zero border.
	assign up_val = flags_s1.row_ge2 ? rd_upper : '0;
	assign lo_val = flags_s1.row_ge1 ? rd_lower : '0;

	// The first column starts from a cleared window (left border).
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i][0] = flags_s1.col_zero ? '0 : win_q[i][1];
			win_next[i][1] = flags_s1.col_zero ? '0 : win_q[i][2];
		end
		win_next[0][2] = up_val;
		win_next[1][2] = lo_val;
		win_next[2][2] = sample_s1;
	end

	assign wr_en    = adv && v_s1;
	assign wr_addr  = col_s1;
	assign wr_upper = lo_val;
	assign wr_lower = sample_s1;

	// Check k looks at the neighborhood shifted down by k[1] and right by k[0];
	// cells pushed past the window are the zero border on the right and bottom.
	for (genvar k = 0; k < NUM_CHECKS; k++) begin : g_check
		localparam int RO = k / 2;
		localparam int CO = k % 2;
		logic signed [SAMPLE_BITS-1:0] nb [3][3];
		logic                          ok;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (i + RO < 3 && j + CO < 3) begin
						nb[i][j] = win_q[i + RO][j + CO];
					end else begin
						nb[i][j] = '0;
					end
				end
			end
			// The upper-left neighbor only rules the cell out when strictly greater.
			ok = !(nb[0][0] > nb[1][1]);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!((i == 0 && j == 0) || (i == 1 && j == 1))) begin
						if (nb[i][j] >= nb[1][1]) begin
							ok = 1'b0;
						end
					end
				end
			end
		end

		assign hit[k] = ok;
	end

	assign cond[0] = flags_s2.row_ge1 && flags_s2.col_ge1;
	assign cond[1] = flags_s2.row_ge1 && flags_s2.col_last;
	assign cond[2] = flags_s2.row_last && flags_s2.col_ge1;
	assign cond[3] = flags_s2.row_last && flags_s2.col_last;

	assign pend    = v_s2 ? (cond & hit) : '0;
	assign row_out = row_s2;
	assign col_out = col_s2;

endmodule

// ===== hdl/glmf_peak_out.sv =====
// ----------------------------------------------------------------------------
// glmf_peak_out
// Holds the results of one sample and hands them out one item at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glmf_peak_out #(
	parameter int MAX_WIDTH  = glmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = glmf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [glmf_pkg::NUM_CHECKS-1:0]   pend,
	input  logic [$clog2(MAX_HEIGHT)-1:0]     row,
	input  logic [$clog2(MAX_WIDTH)-1:0]      col,
	output logic                              adv,
	glmf_peak_if.source                       peaks
);
	import glmf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [NUM_CHECKS-1:0] pend_q;
	logic [ROW_W-1:0]      row_s3;
	logic [COL_W-1:0]      col_s3;
	logic [NUM_CHECKS-1:0] pick;
	logic [NUM_CHECKS-1:0] rest;
	logic                  out_free;
	logic                  take;
	logic                  valid_q;
	logic [COORD_W-1:0]    row_q;
	logic [COORD_W-1:0]    col_q;
	logic                  last_q;
	logic [ROW_W-1:0]      sel_row;
	logic [COL_W-1:0]      sel_col;

	// Lowest pending check goes first: this is the required result order.
	always_comb begin
		pick = '0;
		for (int k = NUM_CHECKS - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				pick = '0;
				pick[k] = 1'b1;
			end
		end
	end

	assign rest     = pend_q & ~pick;
	assign out_free = !valid_q || peaks.ready;
	assign take     = out_free && (pend_q != '0);
	assign adv      = (pend_q == '0) || (take && rest == '0);

	// Checks one and three sit in the sample's own column, two and three in its row.
	always_comb begin
		sel_row = (pick[2] || pick[3]) ? row_s3 : row_s3 - ROW_W'(1);
		sel_col = (pick[1] || pick[3]) ? col_s3 : col_s3 - COL_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pend_q <= pend;
			end else if (take) begin
				pend_q <= rest;
			end
			if (take) begin
				valid_q <= 1'b1;
			end else if (peaks.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s3 <= row;
			col_s3 <= col;
		end
		if (take) begin
			row_q  <= COORD_W'(sel_row);
			col_q  <= COORD_W'(sel_col);
			last_q <= (rest == '0);
		end
	end

	assign peaks.valid       = valid_q;
	assign peaks.peak_row    = row_q;
	assign peaks.peak_col    = col_q;
	assign peaks.last_of_run = last_q;

endmodule

// ===== hdl/grid_local_maximum_finder.sv =====
// ----------------------------------------------------------------------------
// grid_local_maximum_finder
// Finds 3x3 local maxima in a row-major stream of signed grid samples.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the samples channel in row-major order, one per
// accepted item. Each reported hilltop leaves on the peaks channel as one item
// with its row and column; last_of_run marks the final item caused by a sample.
// The cfg channel writes grid_width (index 0) or grid_height (index 1) and
// restarts the frame; write only while no sample is in flight.
// Throughput: one sample per cycle while the receiver keeps up. The line
// stores are read once and written once per sample, and the window pipeline
// advances in lockstep with them. A sample that yields several results holds
// off intake until its last result is taken, since the output register hands
// out one item per cycle. Results pass the s1, s2, pending and output registers.
// Reset: the grid is 1 x 1 and the position is the first cell. The line
// memories are not cleared; rows above the grid read as zero regardless.
// Stall: when the receiver holds ready low, the output item waits in its
// register and intake stops once the stage behind it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_local_maximum_finder #(
	parameter int MAX_WIDTH   = glmf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = glmf_pkg::MAX_HEIGHT_DEF,
	parameter int SAMPLE_BITS = glmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	glmf_sample_if.sink    samples,
	glmf_peak_if.source    peaks,
	glmf_cfg_if.sink       cfg
);
	import glmf_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic                          adv;
	logic                          acc;
	logic [COL_W-1:0]              col;
	logic [ROW_W-1:0]              row;
	pos_flags_t                    flags;
	logic signed [SAMPLE_BITS-1:0] rd_upper;
	logic signed [SAMPLE_BITS-1:0] rd_lower;
	logic                          wr_en;
	logic [COL_W-1:0]              wr_addr;
	logic signed [SAMPLE_BITS-1:0] wr_upper;
	logic signed [SAMPLE_BITS-1:0] wr_lower;
	logic [NUM_CHECKS-1:0]         pend_s2;
	logic [ROW_W-1:0]              row_s2;
	logic [COL_W-1:0]              col_s2;

	assign samples.ready = adv;
	assign acc           = samples.valid && adv;

	glmf_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.acc    (acc),
		.col    (col),
		.row    (row),
		.flags  (flags)
	);

	glmf_line_store #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (acc),
		.rd_addr  (col),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_upper (wr_upper),
		.wr_lower (wr_lower),
		.rd_upper (rd_upper),
		.rd_lower (rd_lower)
	);

	glmf_window #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.acc          (acc),
		.sample_value (samples.sample_value),
		.col          (col),
		.row          (row),
		.flags        (flags),
		.rd_upper     (rd_upper),
		.rd_lower     (rd_lower),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_upper     (wr_upper),
		.wr_lower     (wr_lower),
		.pend         (pend_s2),
		.row_out      (row_s2),
		.col_out      (col_s2)
	);

	glmf_peak_out #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_peak_out (
		.clk    (clk),
		.arst_n (arst_n),
		.pend   (pend_s2),
		.row    (row_s2),
		.col    (col_s2),
		.adv    (adv),
		.peaks  (peaks)
	);

`ifndef SYNTH
	// Intake only stops while results are queued, so a result is on the port next.
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> peaks.valid)
		else $error("intake stalled with no result following");

	// Results of one sample leave back to back with no gap.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(peaks.valid && peaks.ready && !peaks.last_of_run) |=> peaks.valid)
		else $error("gap inside a run of results");

	// A sample with several results always includes a border check (one, two or three).
	a_pend_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(pend_s2) > 1) |-> (pend_s2[1] || pend_s2[2] || pend_s2[3]))
		else $error("several results without a border check");
`endif

endmodule

// ===== dv/tb_grid_local_maximum_finder.sv =====
// ----------------------------------------------------------------------------
// tb_grid_local_maximum_finder
// Self-checking bench for the 3x3 hilltop finder. Samples go in row-major
// order over many grid shapes, including zero and oversize register values.
// A scoreboard class keeps its own line stores and window to predict every
// reported peak, and compares each peak item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_local_maximum_finder;
	import glmf_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PIPE_SETTLE   = 8;
	localparam int RANDOM_ITEMS  = 145;
	localparam int MAX_PHASES    = 60;

	// Register indexes that the block ignores.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} peak_t;

	class hilltop_tracker;
		int              upper_line[MAX_WIDTH_DEF];
		int              lower_line[MAX_WIDTH_DEF];
		int              win[3][3];
		int unsigned     col_pos;
		int unsigned     row_pos;
		logic [CFG_DATA_W-1:0] width_reg;
		logic [CFG_DATA_W-1:0] height_reg;
		peak_t           expected[$];
		int              failures;
		int              peaks_matched;
		int              samples_seen;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i] = 0;
				lower_line[i] = 0;
			end
			width_reg = CFG_DATA_W'(1);
			height_reg = CFG_DATA_W'(1);
			failures = 0;
			peaks_matched = 0;
			samples_seen = 0;
			restart();
		endfunction

		function void restart();
			col_pos = 0;
			row_pos = 0;
			foreach (win[i, j]) win[i][j] = 0;
		endfunction

		function int unsigned clamp(logic [CFG_DATA_W-1:0] v, int unsigned top);
			if (v == 0) return 1;
			if (v > top) return top;
			return v;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_GRID_WIDTH: begin
					width_reg = val;
					restart();
				end
				REG_GRID_HEIGHT: begin
					height_reg = val;
					restart();
				end
				default: begin
				end
			endcase
		endfunction

		// Neighborhood anchored at window row ro, column co; cells past the
		// window are the zero border. A tie with the upper-left cell is allowed.
		function bit hilltop_at(int ro, int co);
			int nb[3][3];
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					nb[i][j] = (i + ro < 3 && j + co < 3) ? win[i + ro][j + co] : 0;
			if (nb[0][0] > nb[1][1]) return 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					if ((i == 0 && j == 0) || (i == 1 && j == 1)) continue;
					if (nb[i][j] >= nb[1][1]) return 1'b0;
				end
			return 1'b1;
		endfunction

		function void note_sample(logic signed [SAMPLE_BITS_DEF-1:0] v);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int unsigned r;
			int          s;
			int          up;
			int          lo;
			peak_t       found[$];
			peak_t       p;
			w = clamp(width_reg, MAX_WIDTH_DEF);
			h = clamp(height_reg, MAX_HEIGHT_DEF);
			c = col_pos;
			r = row_pos;
			s = v;
			samples_seen++;
			if (c >= w || r >= h) begin
				restart();
				c = 0;
				r = 0;
			end
			up = (r >= 2) ? upper_line[c] : 0;
			lo = (r >= 1) ? lower_line[c] : 0;
			if (c == 0) foreach (win[i, j]) win[i][j] = 0;
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = up;
			win[1][2] = lo;
			win[2][2] = s;

			p.last = 1'b0;
			if (r >= 1 && c >= 1 && hilltop_at(0, 0)) begin
				p.row = COORD_W'(r - 1);
				p.col = COORD_W'(c - 1);
				found.push_back(p);
			end
			if (r >= 1 && c == w - 1 && hilltop_at(0, 1)) begin
				p.row = COORD_W'(r - 1);
				p.col = COORD_W'(c);
				found.push_back(p);
			end
			if (r == h - 1 && c >= 1 && hilltop_at(1, 0)) begin
				p.row = COORD_W'(r);
				p.col = COORD_W'(c - 1);
				found.push_back(p);
			end
			if (r == h - 1 && c == w - 1 && hilltop_at(1, 1)) begin
				p.row = COORD_W'(r);
				p.col = COORD_W'(c);
				found.push_back(p);
			end
			if (found.size() > 0) found[found.size() - 1].last = 1'b1;
			foreach (found[k]) expected.push_back(found[k]);

			upper_line[c] = lo;
			lower_line[c] = s;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h) r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_peak(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
			logic last);
			peak_t e;
			if (expected.size() == 0) begin
				$error("unexpected peak item: row %0d col %0d last_of_run %0b",
					row, col, last);
				failures++;
				return;
			end
			e = expected.pop_front();
			if (row !== e.row) begin
				$error("peak_row: expected %0d, actual %0d", e.row, row);
				failures++;
			end
			if (col !== e.col) begin
				$error("peak_col: expected %0d, actual %0d", e.col, col);
				failures++;
			end
			if (last !== e.last) begin
				$error("last_of_run: expected %0b, actual %0b", e.last, last);
				failures++;
			end
			peaks_matched++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;

	hilltop_tracker tracker = new();

	glmf_sample_if samples_ch ();
	glmf_peak_if   peaks_ch ();
	glmf_cfg_if    cfg_ch ();

	grid_local_maximum_finder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.peaks   (peaks_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		peaks_ch.ready = ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && peaks_ch.valid && peaks_ch.ready)
			tracker.check_peak(peaks_ch.peak_row, peaks_ch.peak_col, peaks_ch.last_of_run);
	end

	function void set_pace(pace_t mode);
		case (mode)
			PACE_FULL: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SEND_IDLE: begin
				send_idle_pct = 74;
				stall_pct = 0;
			end
			PACE_RECV_STALL: begin
				send_idle_pct = 0;
				stall_pct = 74;
			end
			default: begin
				send_idle_pct = 13;
				stall_pct = 13;
			end
		endcase
	endfunction

	function logic signed [SAMPLE_BITS_DEF-1:0] random_sample();
		case ($urandom_range(7))
			0, 1: return SAMPLE_BITS_DEF'($urandom);
			2: begin
				case ($urandom_range(2))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					default: return 16'sh0000;
				endcase
			end
			// Narrow values give plenty of ties and true hilltops.
			default: return SAMPLE_BITS_DEF'($signed($urandom_range(12)) - 6);
		endcase
	endfunction

	function logic [CFG_DATA_W-1:0] random_size();
		case ($urandom_range(11))
			0: return CFG_DATA_W'(0);
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(2047);
			default: return CFG_DATA_W'($urandom_range(2, 8));
		endcase
	endfunction

	// Called at a falling edge; returns at a falling edge with valid still high.
	task automatic push_sample(input logic signed [SAMPLE_BITS_DEF-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_ch.valid = 1'b0;
			@(negedge clk);
		end
		samples_ch.valid = 1'b1;
		samples_ch.sample_value = v;
		do @(posedge clk); while (!samples_ch.ready);
		tracker.note_sample(v);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		samples_ch.valid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
	endtask

	// Registers change only once the pipe has emptied, including items that
	// produce no peak.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		repeat (PIPE_SETTLE) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic push_grid(input int vals[]);
		foreach (vals[i]) push_sample(SAMPLE_BITS_DEF'(vals[i]));
	endtask

	initial begin
		int n;
		int random_sent;
		int phase;
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;

		arst_n = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.sample_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_GRID_WIDTH;
		cfg_ch.data = '0;
		peaks_ch.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset leaves a 1 x 1 grid: each sample is judged against the border.
		set_pace(PACE_FULL);
		push_grid('{0, 1, -1, 32767, -32768});

		// A tie with the upper-left neighbor still counts as a hilltop.
		write_reg(REG_GRID_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(3));
		push_grid('{5, 1, 2, 1, 5, 3, 2, 3, 4});
		set_pace(PACE_BOTH);
		push_grid('{-5, -5, -5, -5, -1, -5, -5, -5, -5});

		// Zero sizes behave as one.
		write_reg(REG_GRID_WIDTH, CFG_DATA_W'(0));
		write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(0));
		push_grid('{3, -3});

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS && phase < MAX_PHASES) begin
			case (phase)
				0: begin
					w = CFG_DATA_W'(2047);
					h = CFG_DATA_W'(1);
				end
				1: begin
					w = CFG_DATA_W'(3);
					h = CFG_DATA_W'(2047);
				end
				2: begin
					w = CFG_DATA_W'(1);
					h = CFG_DATA_W'(5);
				end
				default: begin
					w = random_size();
					h = random_size();
				end
			endcase
			if ($urandom_range(1)) begin
				write_reg(REG_GRID_WIDTH, w);
				write_reg(REG_GRID_HEIGHT, h);
			end else begin
				write_reg(REG_GRID_HEIGHT, h);
				write_reg(REG_GRID_WIDTH, w);
			end
			if ($urandom_range(3) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
					CFG_DATA_W'($urandom));
			set_pace(pace_t'(phase % 4));
			n = $urandom_range(10, 30);
			for (int i = 0; i < n; i++) begin
				if (i == n / 2 && phase % 5 == 1) wait_drained();
				push_sample(random_sample());
			end
			random_sent += n;
			phase++;
		end

		wait_drained();
		repeat (PIPE_SETTLE * 4) @(negedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
